// ===== rtl/wsp_pkg.sv =====
// Shared types and constants of the world-to-screen projection unit.
package wsp_pkg;

	localparam int FracBits = 16;
	localparam int QW       = 32;
	localparam int DivW     = QW + FracBits + 1;   // signed dividend width
	localparam int WMin     = ((1 << FracBits) + 50) / 100;
	localparam int NumRegs  = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 64;
	localparam int QueueDepth = 4;
	localparam int QPtrW      = 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_X0   = 3'd0,
		REG_X1   = 3'd1,
		REG_Y0   = 3'd2,
		REG_Y1   = 3'd3,
		REG_W0   = 3'd4,
		REG_W1   = 3'd5,
		REG_ORG  = 3'd6,
		REG_SIZE = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [QW-1:0] cx;
		logic signed [QW-1:0] cy;
		logic signed [QW-1:0] cw;
		logic                 vis;
	} clip_t;

	typedef struct packed {
		logic signed [QW-1:0] sx;
		logic signed [QW-1:0] sy;
		logic                 vis;
	} screen_t;

	function automatic logic signed [QW-1:0] sat_q(input logic signed [95:0] v);
		logic signed [95:0] hi;
		logic signed [95:0] lo;
		hi = 96'sd2147483647;
		lo = -96'sd2147483648;
		if (v > hi) return QW'(hi);
		if (v < lo) return QW'(lo);
		return v[QW-1:0];
	endfunction

endpackage

// ===== rtl/wsp_if.sv =====
// Valid/ready stream interfaces for points and screen results.
interface wsp_point_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [31:0] world_z;
	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_screen_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic              visible;
	modport source (output valid, screen_x, screen_y, visible, input ready);
	modport sink   (input valid, screen_x, screen_y, visible, output ready);
endinterface

// ===== rtl/world_to_screen_projection_unit.sv =====
// Top level of the world-to-screen projection unit.
// Channels: pt (sink) carries world_x/y/z Q16.16 points; scr (source)
// returns screen_x/y Q16.16 pixels and visible, one result per point,
// in order. Both use valid/ready; a beat moves when both are high.
// Config: cfg_we/cfg_idx/cfg_data write one of eight registers (three
// matrix rows as pairs, viewport origin, viewport size); write while idle.
// Stages: 3 in the transform front end, 1 in the queue, 49 in the
// bit-per-stage divider and 2 in the viewport map. Throughput: one
// point per cycle while scr.ready stays high, as the divider is
// fully pipelined.
// The front end and back end stall separately; a 4-entry queue between
// them absorbs back-end stalls. When the receiver drops ready, the back
// end holds, the queue fills and then pt.ready falls.
// Reset clears the config registers to zero and empties every stage.
module world_to_screen_projection_unit import wsp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	wsp_point_if.sink           pt,
	wsp_screen_if.source        scr
);

	logic [CfgDataW-1:0] regs_q [6];
	logic [31:0]         org_q, size_q;
	logic                f_v, f_r, b_v, b_r;
	clip_t               f_d, b_d;
	screen_t             s_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) regs_q[i] <= '0;
			org_q <= '0; size_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_X0, REG_X1, REG_Y0, REG_Y1, REG_W0, REG_W1:
					regs_q[cfg_idx] <= cfg_data;
				REG_ORG:  org_q  <= cfg_data[31:0];
				REG_SIZE: size_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	wsp_front u_front (
		.clk, .arst_n,
		.in_valid(pt.valid), .in_ready(pt.ready),
		.px(pt.world_x), .py(pt.world_y), .pz(pt.world_z),
		.m_x0(regs_q[0]), .m_x1(regs_q[1]), .m_y0(regs_q[2]),
		.m_y1(regs_q[3]), .m_w0(regs_q[4]), .m_w1(regs_q[5]),
		.out_valid(f_v), .out_ready(f_r), .out_data(f_d)
	);

	wsp_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_v), .wr_ready(f_r), .wr_data(f_d),
		.rd_valid(b_v), .rd_ready(b_r), .rd_data(b_d)
	);

	wsp_back u_back (
		.clk, .arst_n,
		.in_valid(b_v), .in_ready(b_r), .in_data(b_d),
		.org(org_q), .size(size_q),
		.out_valid(scr.valid), .out_ready(scr.ready), .out_data(s_d)
	);

	assign scr.screen_x = s_d.sx;
	assign scr.screen_y = s_d.sy;
	assign scr.visible  = s_d.vis;

endmodule

// ===== rtl/wsp_front.sv =====
// Front end: matrix-row transform and visibility classification, 3 stages.
module wsp_front import wsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [QW-1:0]   px,
	input  logic signed [QW-1:0]   py,
	input  logic signed [QW-1:0]   pz,
	input  logic [CfgDataW-1:0]    m_x0,
	input  logic [CfgDataW-1:0]    m_x1,
	input  logic [CfgDataW-1:0]    m_y0,
	input  logic [CfgDataW-1:0]    m_y1,
	input  logic [CfgDataW-1:0]    m_w0,
	input  logic [CfgDataW-1:0]    m_w1,
	output logic                   out_valid,
	input  logic                   out_ready,
	output clip_t                  out_data
);

	// Three shifted 64-bit products plus a constant need 50 signed bits.
	localparam int SumW = 2*QW - FracBits + 2;

	logic                        v_s1, v_s2, v_s3;
	logic signed [2*QW-1:0]      prod_s1 [9];
	logic signed [QW-1:0]        cst_s1  [3];
	logic signed [SumW-1:0]      sum_s2  [3];
	clip_t                       data_s3;
	logic                        adv;
	logic signed [QW-1:0]        mel [9];
	logic signed [QW-1:0]        pt  [3];

	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;

	always_comb begin
		mel[0] = m_x0[31:0]; mel[1] = m_x0[63:32]; mel[2] = m_x1[31:0];
		mel[3] = m_y0[31:0]; mel[4] = m_y0[63:32]; mel[5] = m_y1[31:0];
		mel[6] = m_w0[31:0]; mel[7] = m_w0[63:32]; mel[8] = m_w1[31:0];
		pt[0] = px; pt[1] = py; pt[2] = pz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++)
				prod_s1[i] <= (2*QW)'(mel[i]) * (2*QW)'(pt[i%3]);
			cst_s1[0] <= m_x1[63:32];
			cst_s1[1] <= m_y1[63:32];
			cst_s1[2] <= m_w1[63:32];
			for (int r = 0; r < 3; r++)
				sum_s2[r] <= SumW'(cst_s1[r])
					+ SumW'($signed(prod_s1[3*r][2*QW-1:FracBits]))
					+ SumW'($signed(prod_s1[3*r+1][2*QW-1:FracBits]))
					+ SumW'($signed(prod_s1[3*r+2][2*QW-1:FracBits]));
			data_s3.cx  <= sat_q(96'(sum_s2[0]));
			data_s3.cy  <= sat_q(96'(sum_s2[1]));
			data_s3.cw  <= sat_q(96'(sum_s2[2]));
			data_s3.vis <= sum_s2[2] >= SumW'(WMin);
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

// ===== rtl/wsp_queue.sv =====
// Small FIFO between the front and back ends.
module wsp_queue import wsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  clip_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output clip_t rd_data
);

	clip_t            mem_q [QueueDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0]   cnt_q;
	logic             wr, rd;

	assign wr_ready = cnt_q != (QPtrW+1)'(QueueDepth);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== rtl/wsp_div.sv =====
// Pipelined signed divider: (c << FracBits) / w, one quotient bit per stage.
module wsp_div import wsp_pkg::*; (
	input  logic                 clk,
	input  logic                 adv,
	input  logic signed [QW-1:0] num,
	input  logic signed [QW-1:0] den,
	output logic signed [QW-1:0] quo
);

	localparam int NumW = QW + FracBits;

	// Divisor is always positive (visible points only); dividend magnitude.
	logic [NumW-1:0] rem_q [NumW+1];
	logic [NumW-1:0] qb_q  [NumW+1];
	logic [QW-1:0]   d_q   [NumW+1];
	logic            neg_q [NumW+1];
	logic [NumW:0]   qs;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= num[QW-1] ? NumW'(-(NumW'(num))) << FracBits
				: NumW'(num) << FracBits;
			qb_q[0]  <= '0;
			d_q[0]   <= den;
			neg_q[0] <= num[QW-1];
			for (int k = 0; k < NumW; k++) begin
				logic [NumW:0] part;
				logic [NumW:0] trial;
				part  = (NumW+1)'(rem_q[k] >> (NumW-1-k));
				trial = part - (NumW+1)'(d_q[k]);
				d_q[k+1]   <= d_q[k];
				neg_q[k+1] <= neg_q[k];
				if (!trial[NumW]) begin
					rem_q[k+1] <= rem_q[k] - (NumW'(d_q[k]) << (NumW-1-k));
					qb_q[k+1]  <= qb_q[k] | (NumW'(1) << (NumW-1-k));
				end else begin
					rem_q[k+1] <= rem_q[k];
					qb_q[k+1]  <= qb_q[k];
				end
			end
		end
	end

	always_comb begin
		qs = neg_q[NumW] ? -(NumW+1)'(qb_q[NumW]) : (NumW+1)'(qb_q[NumW]);
		quo = sat_q(96'($signed(qs)));
	end

endmodule

// ===== rtl/wsp_back.sv =====
// Back end: perspective divide and viewport mapping with output register.
module wsp_back import wsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  clip_t            in_data,
	input  logic [31:0]      org,
	input  logic [31:0]      size,
	output logic             out_valid,
	input  logic             out_ready,
	output screen_t          out_data
);

	localparam int DivLat = QW + FracBits + 1;

	logic                  v_q [DivLat];
	logic                  vis_q [DivLat];
	logic                  v_m1, vis_m1, v_m2;
	logic signed [QW-1:0]  nx, ny;
	logic signed [QW+16:0] px_m1, py_m1;
	screen_t               res_m2;
	logic                  adv;
	logic signed [QW-1:0]  cw_safe;
	logic signed [QW+32:0] base_x, base_y;

	assign adv      = !v_m2 || out_ready;
	assign in_ready = adv;
	assign cw_safe  = in_data.vis ? in_data.cw : QW'(1);

	wsp_div u_div_x (.clk, .adv, .num(in_data.cx), .den(cw_safe), .quo(nx));
	wsp_div u_div_y (.clk, .adv, .num(in_data.cy), .den(cw_safe), .quo(ny));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DivLat; i++) v_q[i] <= 1'b0;
			v_m1 <= 1'b0; v_m2 <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < DivLat; i++) v_q[i] <= v_q[i-1];
			v_m1 <= v_q[DivLat-1];
			v_m2 <= v_m1;
		end
	end

	always_comb begin
		base_x = (QW+33)'({1'b0, size[15:1]}) * (QW+33)'(1 << FracBits)
			+ (QW+33)'($signed(org[15:0])) * (QW+33)'(1 << FracBits);
		base_y = (QW+33)'({1'b0, size[31:17]}) * (QW+33)'(1 << FracBits)
			+ (QW+33)'($signed(org[31:16])) * (QW+33)'(1 << FracBits);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_q[0] <= in_data.vis;
			for (int i = 1; i < DivLat; i++) vis_q[i] <= vis_q[i-1];
			vis_m1 <= vis_q[DivLat-1];
			px_m1 <= (QW+17)'(nx) * (QW+17)'($signed({2'b0, size[15:1]}));
			py_m1 <= (QW+17)'(ny) * (QW+17)'($signed({2'b0, size[31:17]}));
			res_m2.vis <= vis_m1;
			res_m2.sx  <= vis_m1 ? sat_q(96'(base_x) + 96'(px_m1)) : '0;
			res_m2.sy  <= vis_m1 ? sat_q(96'(base_y) - 96'(py_m1)) : '0;
		end
	end

	assign out_valid = v_m2;
	assign out_data  = res_m2;

endmodule

// ===== rtl/wsp_checker.sv =====
// Port-level checks of the projection unit, bound to the top level.
module wsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        scr_valid,
	input logic        scr_ready,
	input logic [31:0] scr_x,
	input logic [31:0] scr_y,
	input logic        scr_vis
);

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		scr_valid && !scr_vis |-> scr_x == '0 && scr_y == '0)
		else $error("hidden point with nonzero coordinates");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scr_valid && !scr_ready |=> scr_valid && $stable(scr_x) && $stable(scr_y))
		else $error("result changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !scr_valid)
		else $error("result valid right after reset");

endmodule

bind world_to_screen_projection_unit wsp_checker u_chk (
	.clk, .arst_n,
	.scr_valid(scr.valid), .scr_ready(scr.ready),
	.scr_x(scr.screen_x), .scr_y(scr.screen_y), .scr_vis(scr.visible)
);
